// ===== rtl/csa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and codes for the checked signed ALU.
// ----------------------------------------------------------------------------
package csa_pkg;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_REM = 4'd4,
    MODE_AND = 4'd5,
    MODE_OR  = 4'd6,
    MODE_XOR = 4'd7,
    MODE_SHL = 4'd8,
    MODE_SAR = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_OVER   = 2'd1,
    ERR_UNDER  = 2'd2,
    ERR_DOMAIN = 2'd3
  } err_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic [7:0]         shift_amount;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [1:0]         error_code;
    logic               less_flag;
    logic               equal_flag;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/csa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module csa_div #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic      [WIDTH-1:0] quotient,
  output logic      [WIDTH-1:0] remainder
);

  logic [WIDTH-1:0] rem_q [WIDTH];
  logic [WIDTH-1:0] quo_q [WIDTH];
  logic [WIDTH-1:0] dvs_q [WIDTH];

  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    logic [WIDTH-1:0] rem_in, quo_in, dvs_in, trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend;
      assign dvs_in = divisor;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    // remainder stays below divisor <= 2^(WIDTH-1), so the shift fits
    assign trial = {rem_in[WIDTH-2:0], quo_in[WIDTH-1]};
    assign ge    = (trial >= dvs_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? (trial - dvs_in) : trial;
        quo_q[k] <= {quo_in[WIDTH-2:0], ge};
        dvs_q[k] <= dvs_in;
      end
    end
  end

  assign quotient  = quo_q[WIDTH-1];
  assign remainder = rem_q[WIDTH-1];

endmodule
`default_nettype wire

// ===== rtl/checked_signed_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle while req_stall is low; the divider has one stage per quotient bit.
// A stalled response parks the next one in a skid register; the pipeline freezes
// and req_stall rises only while that register is full (req_stall is registered).
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// checked_signed_alu
// Overflow-checked signed integer ALU: add, sub, mul, div, rem, logic ops
// and shifts, with error code and signed compare flags on every transaction.
// ----------------------------------------------------------------------------
module checked_signed_alu
  import csa_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // multiplier split into halves, at most 32 x 32 per partial product
  localparam int HW = (WIDTH + 1) / 2;
  localparam int PW = 2 * HW;
  localparam int DL = WIDTH - 4;   // delay from stage 5 to divider output

  localparam logic [WIDTH-1:0] MIN_W  = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [7:0]       SH_LIM = 8'(WIDTH);
  localparam logic [7:0]       SH_MAX = 8'(WIDTH - 1);

  typedef struct packed {
    logic [3:0]       mode;
    logic [WIDTH-1:0] res;
    err_t             err;
    logic             less;
    logic             eq;
    logic             neg;   // operand signs differ
    logic             sa;    // operand_a negative
  } side_t;

  // one global advance: the pipeline moves unless the skid register is full
  logic adv;
  logic out_free;
  logic skid_v;
  rsp_t skid;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign adv       = !skid_v;
  assign req_stall = skid_v;

  // --------------------------------------------------------------------------
  // Stage 1: capture, truncate to WIDTH, magnitudes
  // --------------------------------------------------------------------------
  logic             s1_v;
  logic [3:0]       s1_mode;
  logic [WIDTH-1:0] s1_a, s1_b, s1_ma, s1_mb;
  logic [7:0]       s1_sh;

  logic [WIDTH-1:0] a_in, b_in;
  assign a_in = req.operand_a[WIDTH-1:0];
  assign b_in = req.operand_b[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= req.mode;
      s1_a    <= a_in;
      s1_b    <= b_in;
      s1_ma   <= a_in[WIDTH-1] ? (WIDTH'(0) - a_in) : a_in;
      s1_mb   <= b_in[WIDTH-1] ? (WIDTH'(0) - b_in) : b_in;
      s1_sh   <= req.shift_amount;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: simple ops, pre-checks, partial products
  // --------------------------------------------------------------------------
  logic [WIDTH:0]   sum, diff;
  logic [7:0]       sar_sh;
  side_t            s2_next;
  logic [PW-1:0]    ma_e, mb_e;

  assign ma_e = PW'(s1_ma);
  assign mb_e = PW'(s1_mb);

  always_comb begin
    sum    = {s1_a[WIDTH-1], s1_a} + {s1_b[WIDTH-1], s1_b};
    diff   = {s1_a[WIDTH-1], s1_a} - {s1_b[WIDTH-1], s1_b};
    sar_sh = (s1_sh < SH_LIM) ? s1_sh : SH_MAX;

    s2_next.mode = s1_mode;
    s2_next.res  = '0;
    s2_next.err  = ERR_NONE;
    s2_next.less = ($signed(s1_a) < $signed(s1_b));
    s2_next.eq   = (s1_a == s1_b);
    s2_next.neg  = s1_a[WIDTH-1] ^ s1_b[WIDTH-1];
    s2_next.sa   = s1_a[WIDTH-1];

    case (s1_mode)
      MODE_ADD: begin
        if (sum[WIDTH] != sum[WIDTH-1]) begin
          s2_next.err = sum[WIDTH] ? ERR_UNDER : ERR_OVER;
        end else begin
          s2_next.res = sum[WIDTH-1:0];
        end
      end
      MODE_SUB: begin
        if (diff[WIDTH] != diff[WIDTH-1]) begin
          s2_next.err = diff[WIDTH] ? ERR_UNDER : ERR_OVER;
        end else begin
          s2_next.res = diff[WIDTH-1:0];
        end
      end
      MODE_MUL: begin
        if (s1_a == '0 || s1_b == '0) begin
          s2_next.err = ERR_DOMAIN;
        end
      end
      MODE_DIV: begin
        if (s1_b == '0) begin
          s2_next.err = ERR_DOMAIN;
        end else if (s1_a == MIN_W && s1_b == '1) begin
          s2_next.err = ERR_OVER;
        end
      end
      MODE_REM: begin
        if (s1_b == '0) begin
          s2_next.err = ERR_DOMAIN;
        end
      end
      MODE_AND: s2_next.res = s1_a & s1_b;
      MODE_OR:  s2_next.res = s1_a | s1_b;
      MODE_XOR: s2_next.res = s1_a ^ s1_b;
      MODE_SHL: s2_next.res = (s1_sh < SH_LIM) ? (s1_a << s1_sh) : '0;
      MODE_SAR: s2_next.res = WIDTH'($signed(s1_a) >>> sar_sh);
      default:  s2_next.err = ERR_DOMAIN;
    endcase
  end

  logic          s2_v;
  side_t         s2;
  logic [PW-1:0] pp_ll, pp_lh, pp_hl, pp_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2    <= s2_next;
      pp_ll <= PW'(ma_e[HW-1:0]) * PW'(mb_e[HW-1:0]);
      pp_lh <= PW'(ma_e[HW-1:0]) * PW'(mb_e[PW-1:HW]);
      pp_hl <= PW'(ma_e[PW-1:HW]) * PW'(mb_e[HW-1:0]);
      pp_hh <= PW'(ma_e[PW-1:HW]) * PW'(mb_e[PW-1:HW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: middle partial sum; stage 4: full product
  // --------------------------------------------------------------------------
  logic          s3_v, s4_v;
  side_t         s3, s4;
  logic [PW:0]   s3_mid;
  logic [PW-1:0] s3_ll, s3_hh;
  logic [2*PW-1:0] s4_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3      <= s2;
      s3_mid  <= (PW+1)'(pp_lh) + (PW+1)'(pp_hl);
      s3_ll   <= pp_ll;
      s3_hh   <= pp_hh;
      s4      <= s3;
      s4_prod <= (2*PW)'(s3_ll) + ((2*PW)'(s3_mid) << HW) + ((2*PW)'(s3_hh) << PW);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: multiply range check
  // --------------------------------------------------------------------------
  side_t            s5_next;
  logic             prod_hi;
  logic [WIDTH-1:0] prod_lo;

  assign prod_hi = |s4_prod[2*PW-1:WIDTH];
  assign prod_lo = s4_prod[WIDTH-1:0];

  always_comb begin
    s5_next = s4;
    if (s4.mode == MODE_MUL && s4.err == ERR_NONE) begin
      if (!s4.neg && (prod_hi || prod_lo[WIDTH-1])) begin
        s5_next.err = ERR_OVER;
      end else if (s4.neg && (prod_hi || prod_lo > MIN_W)) begin
        s5_next.err = ERR_UNDER;
      end else begin
        s5_next.res = s4.neg ? (WIDTH'(0) - prod_lo) : prod_lo;
      end
    end
  end

  logic  s5_v;
  side_t s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5 <= s5_next;
    end
  end

  // --------------------------------------------------------------------------
  // Delay line to meet the divider output
  // --------------------------------------------------------------------------
  logic [DL-1:0] dly_v;
  side_t         dly [DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_v <= '0;
    end else if (adv) begin
      dly_v <= {dly_v[DL-2:0], s5_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= s5;
      for (int i = 1; i < DL; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: magnitudes in from stage 1, result aligned with dly end
  // --------------------------------------------------------------------------
  logic [WIDTH-1:0] quo, remd;

  csa_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk       (clk),
    .en        (adv),
    .dividend  (s1_ma),
    .divisor   (s1_mb),
    .quotient  (quo),
    .remainder (remd)
  );

  // --------------------------------------------------------------------------
  // Output register: fold in quotient / remainder, zero on any error
  // --------------------------------------------------------------------------
  side_t            fin;
  logic [WIDTH-1:0] fin_res;
  rsp_t             rsp_next;

  assign fin = dly[DL-1];

  always_comb begin
    fin_res = fin.res;
    case (fin.mode)
      MODE_DIV: fin_res = fin.neg ? (WIDTH'(0) - quo) : quo;
      MODE_REM: fin_res = fin.sa ? (WIDTH'(0) - remd) : remd;
      default:  fin_res = fin.res;
    endcase
    if (fin.err != ERR_NONE) begin
      fin_res = '0;
    end
    rsp_next.result     = 64'($signed(fin_res));
    rsp_next.error_code = fin.err;
    rsp_next.less_flag  = fin.less;
    rsp_next.equal_flag = fin.eq;
  end

  // skid register catches the transaction that arrives while the output is stalled;
  // while it is full the pipeline holds and the skid entry goes out first
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_free) begin
        rsp_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (out_free) begin
      rsp_valid <= dly_v[DL-1];
    end else if (dly_v[DL-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_free) begin
        rsp <= skid;
      end
    end else if (out_free) begin
      rsp <= rsp_next;
    end else begin
      skid <= rsp_next;
    end
  end

endmodule
`default_nettype wire
